[sv/fqu_pkg.sv]
// Shared definitions for the record queue with undo log: payload widths,
// parameter defaults and the operation, status and log-kind codes.
`default_nettype none

package fqu_pkg;

   localparam int QUEUE_DEPTH_DEF   = 16;
   localparam int HISTORY_DEPTH_DEF = 32;
   localparam int HANDLE_BITS_DEF   = 16;

   localparam int MODE_BITS   = 2;
   localparam int RECORD_BITS = 16;
   localparam int STATUS_BITS = 2;
   localparam int OCC_BITS    = 5;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_ENQ  = 2'd0,
      MODE_DEQ  = 2'd1,
      MODE_UNDO = 2'd2
   } mode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_NONE  = 2'd3
   } status_type;

   typedef enum logic {
      KIND_ENQ = 1'b0,
      KIND_DEQ = 1'b1
   } kind_type;

endpackage

`default_nettype wire

[sv/fqu_if.sv]
// Valid/ready channel interfaces for the operation and result transactions.
// Depends on fqu_pkg for the payload widths.
`default_nettype none

interface fqu_req_if;
   logic                             valid;
   logic                             ready;
   logic [fqu_pkg::MODE_BITS-1:0]    mode;
   logic [fqu_pkg::RECORD_BITS-1:0]  record_id;

   modport source (output valid, output mode, output record_id, input ready);
   modport sink   (input valid, input mode, input record_id, output ready);
endinterface

interface fqu_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [fqu_pkg::STATUS_BITS-1:0]  status;
   logic [fqu_pkg::RECORD_BITS-1:0]  record_out;
   logic                             undone_kind;
   logic [fqu_pkg::OCC_BITS-1:0]     occupancy;

   modport source (output valid, output status, output record_out, output undone_kind,
                   output occupancy, input ready);
   modport sink   (input valid, input status, input record_out, input undone_kind,
                   input occupancy, output ready);
endinterface

`default_nettype wire

[sv/fqu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fqu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/fifo_queue_with_undo_log.sv]
// Top level of the record queue with undo log.
// Depends on fqu_pkg, fqu_req_if, fqu_rsp_if and fqu_ram.
//
// Usage:
//   req_if carries one operation per transaction: mode 0 enqueues record_id,
//   mode 1 dequeues the head, mode 2 undoes the newest logged operation;
//   mode 3 does nothing and reports the occupancy.
//   rsp_if returns exactly one result transaction per operation, in order:
//   status, the record dequeued or restored, the kind undone and the queue
//   occupancy after the operation.
//   rsp_if.valid rises in the cycle after acceptance. While rsp_if is
//   not stalled, one operation is taken every cycle; the head entry and
//   the newest log entry sit in registers, and the two RAMs prefetch the
//   entries behind them, so no operation waits on a RAM read.
//   The result register is the only buffer: while a result is held and
//   rsp_if.ready is low, req_if.ready is low; it rises again in the cycle
//   the held result is taken.
//   Reset (synchronous) empties the queue and the log; the RAM contents
//   are not cleared and are read only after being written.
//   A full log overwrites its oldest entry; a full queue rejects enqueues.
`default_nettype none

module fifo_queue_with_undo_log #(
   parameter int QUEUE_DEPTH   = fqu_pkg::QUEUE_DEPTH_DEF,
   parameter int HISTORY_DEPTH = fqu_pkg::HISTORY_DEPTH_DEF,
   parameter int HANDLE_BITS   = fqu_pkg::HANDLE_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   fqu_req_if.sink   req_if,
   fqu_rsp_if.source rsp_if
);

   localparam int QA = $clog2(QUEUE_DEPTH);
   localparam int QC = $clog2(QUEUE_DEPTH + 1);
   localparam int TW = QA + 1;
   localparam int HA = $clog2(HISTORY_DEPTH);
   localparam int HC = $clog2(HISTORY_DEPTH + 1);
   localparam int EW = HANDLE_BITS + 1;

   logic accept;

   logic [QA-1:0]          head_ff, head_in;
   logic [QC-1:0]          count_ff, count_in;
   logic [HANDLE_BITS-1:0] hd_ff, hd_in;
   logic                   fwd_valid_ff, fwd_valid_in;
   logic [HANDLE_BITS-1:0] fwd_data_ff, fwd_data_in;

   logic [HA-1:0]          top_ff, top_in;
   logic [HC-1:0]          hcount_ff, hcount_in;
   logic [EW-1:0]          tos_ff, tos_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [fqu_pkg::STATUS_BITS-1:0]     status_ff;
   logic [fqu_pkg::RECORD_BITS-1:0]     record_ff, record_in;
   logic                                kind_ff;
   logic [fqu_pkg::OCC_BITS-1:0]        occ_ff, occ_in;

   fqu_pkg::status_type    status_in;
   fqu_pkg::kind_type      kind_in;
   logic [HANDLE_BITS-1:0] rout;

   logic [31:0]            rec_wide;
   logic [31:0]            out_wide;
   logic [31:0]            occ_wide;
   logic [HANDLE_BITS-1:0] req_handle;

   logic [QA-1:0]          head_inc, head_dec;
   logic [TW-1:0]          tail_sum;
   logic [QA-1:0]          tail;
   logic                   q_full, q_empty;
   logic [HA-1:0]          top_inc, top_dec, top_rd1;

   logic                   q_wr_en;
   logic [QA-1:0]          q_wr_addr, q_rd_addr;
   logic [HANDLE_BITS-1:0] q_wr_data, q_rd_data, q_next;

   logic                   push;
   logic [EW-1:0]          push_entry;
   logic [HA-1:0]          h_rd_addr;
   logic [EW-1:0]          h_rd_data;

   logic                   tos_kind;
   logic [HANDLE_BITS-1:0] tos_handle;

   assign accept       = req_if.valid && req_if.ready;
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;

   assign rec_wide   = 32'(req_if.record_id);
   assign req_handle = rec_wide[HANDLE_BITS-1:0];

   assign head_inc = (head_ff == QA'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QA'(1);
   assign head_dec = (head_ff == '0) ? QA'(QUEUE_DEPTH - 1) : head_ff - QA'(1);
   assign tail_sum = TW'(head_ff) + TW'(count_ff);
   assign tail     = (tail_sum >= TW'(QUEUE_DEPTH)) ? QA'(tail_sum - TW'(QUEUE_DEPTH))
                                                     : QA'(tail_sum);
   assign q_full   = (count_ff == QC'(QUEUE_DEPTH));
   assign q_empty  = (count_ff == '0);

   assign top_inc = (top_ff == HA'(HISTORY_DEPTH - 1)) ? '0 : top_ff + HA'(1);
   assign top_dec = (top_ff == '0) ? HA'(HISTORY_DEPTH - 1) : top_ff - HA'(1);

   assign tos_kind   = tos_ff[EW-1];
   assign tos_handle = tos_ff[HANDLE_BITS-1:0];

   assign q_next = fwd_valid_ff ? fwd_data_ff : q_rd_data;

   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      hd_in      = hd_ff;
      top_in     = top_ff;
      hcount_in  = hcount_ff;
      tos_in     = tos_ff;
      q_wr_en    = 1'b0;
      q_wr_addr  = tail;
      q_wr_data  = req_handle;
      push       = 1'b0;
      push_entry = {fqu_pkg::KIND_ENQ, req_handle};
      status_in  = fqu_pkg::STATUS_OK;
      kind_in    = fqu_pkg::KIND_ENQ;
      rout       = '0;
      if (accept) begin
         case (req_if.mode)
            fqu_pkg::MODE_ENQ: begin
               if (q_full) begin
                  status_in = fqu_pkg::STATUS_FULL;
               end else begin
                  q_wr_en  = 1'b1;
                  count_in = count_ff + QC'(1);
                  push     = 1'b1;
                  if (q_empty) begin
                     hd_in = req_handle;
                  end
               end
            end
            fqu_pkg::MODE_DEQ: begin
               if (q_empty) begin
                  status_in = fqu_pkg::STATUS_EMPTY;
               end else begin
                  rout       = hd_ff;
                  head_in    = head_inc;
                  hd_in      = q_next;
                  count_in   = count_ff - QC'(1);
                  push       = 1'b1;
                  push_entry = {fqu_pkg::KIND_DEQ, hd_ff};
               end
            end
            fqu_pkg::MODE_UNDO: begin
               if (hcount_ff == '0) begin
                  status_in = fqu_pkg::STATUS_NONE;
               end else begin
                  top_in    = top_dec;
                  hcount_in = hcount_ff - HC'(1);
                  tos_in    = h_rd_data;
                  if (tos_kind == fqu_pkg::KIND_ENQ) begin
                     if (q_empty) begin
                        status_in = fqu_pkg::STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - QC'(1);
                        rout     = tos_handle;
                     end
                  end else begin
                     if (q_full) begin
                        status_in = fqu_pkg::STATUS_FULL;
                     end else begin
                        head_in   = head_dec;
                        q_wr_en   = 1'b1;
                        q_wr_addr = head_dec;
                        q_wr_data = tos_handle;
                        hd_in     = tos_handle;
                        count_in  = count_ff + QC'(1);
                        rout      = tos_handle;
                        kind_in   = fqu_pkg::KIND_DEQ;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (push) begin
         top_in    = top_inc;
         hcount_in = (hcount_ff == HC'(HISTORY_DEPTH)) ? hcount_ff : hcount_ff + HC'(1);
         tos_in    = push_entry;
      end
   end

   assign q_rd_addr    = (head_in == QA'(QUEUE_DEPTH - 1)) ? '0 : head_in + QA'(1);
   assign fwd_valid_in = q_wr_en && (q_wr_addr == q_rd_addr);
   assign fwd_data_in  = q_wr_data;

   assign top_rd1   = (top_in == '0) ? HA'(HISTORY_DEPTH - 1) : top_in - HA'(1);
   assign h_rd_addr = (top_rd1 == '0) ? HA'(HISTORY_DEPTH - 1) : top_rd1 - HA'(1);

   assign out_wide  = 32'(rout);
   assign record_in = out_wide[fqu_pkg::RECORD_BITS-1:0];
   assign occ_wide  = 32'(count_in);
   assign occ_in    = occ_wide[fqu_pkg::OCC_BITS-1:0];

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_if.ready);

   fqu_ram #(
      .WIDTH (HANDLE_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (q_wr_addr),
      .wr_data (q_wr_data),
      .rd_addr (q_rd_addr),
      .rd_data (q_rd_data)
   );

   fqu_ram #(
      .WIDTH (EW),
      .DEPTH (HISTORY_DEPTH)
   ) u_history_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (top_ff),
      .wr_data (push_entry),
      .rd_addr (h_rd_addr),
      .rd_data (h_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         top_ff       <= '0;
         hcount_ff    <= '0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         hcount_ff    <= hcount_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hd_ff       <= hd_in;
      tos_ff      <= tos_in;
      fwd_data_ff <= fwd_data_in;
      if (accept) begin
         status_ff <= status_in;
         record_ff <= record_in;
         kind_ff   <= kind_in;
         occ_ff    <= occ_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = status_ff;
   assign rsp_if.record_out  = record_ff;
   assign rsp_if.undone_kind = kind_ff;
   assign rsp_if.occupancy   = occ_ff;

   a_enq_grows: assert property (@(posedge clock) disable iff (reset)
      accept && (req_if.mode == fqu_pkg::MODE_ENQ) && !q_full
      |=> count_ff == QC'($past(count_ff) + QC'(1)))
      else $error("accepted enqueue did not grow the queue");

   a_log_bound: assert property (@(posedge clock) disable iff (reset)
      hcount_ff <= HC'(HISTORY_DEPTH))
      else $error("log count beyond log depth");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QC'(QUEUE_DEPTH))
      else $error("queue count beyond queue depth");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted transaction gave no result");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for the record queue with undo log: drives operation transactions,
// predicts each result and checks every result transaction against it.
// Depends on fqu_pkg, fqu_req_if, fqu_rsp_if and fifo_queue_with_undo_log.

module tb_top;

   localparam int QDEPTH = fqu_pkg::QUEUE_DEPTH_DEF;
   localparam int HDEPTH = fqu_pkg::HISTORY_DEPTH_DEF;
   localparam int RBITS  = fqu_pkg::RECORD_BITS;
   localparam int OBITS  = fqu_pkg::OCC_BITS;
   localparam logic [RBITS-1:0] HANDLE_MASK =
      {RBITS{1'b1}} >> (RBITS - fqu_pkg::HANDLE_BITS_DEF);
   localparam logic [fqu_pkg::MODE_BITS-1:0] MODE_IGNORED = 2'd3;

   typedef struct packed {
      fqu_pkg::status_type  status;
      logic [RBITS-1:0]     record_out;
      fqu_pkg::kind_type    undone_kind;
      logic [OBITS-1:0]     occupancy;
   } queue_result_type;

   logic clock = 1'b0;
   logic reset;

   fqu_req_if req_if ();
   fqu_rsp_if rsp_if ();

   fifo_queue_with_undo_log dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predicted queue and undo log
   logic [RBITS-1:0]       slot_mem [QDEPTH];
   int unsigned            head_pos = 0;
   int unsigned            fill = 0;
   fqu_pkg::kind_type      log_kind [HDEPTH];
   logic [RBITS-1:0]       log_handle [HDEPTH];
   int unsigned            log_top = 0;
   int unsigned            log_fill = 0;

   queue_result_type pending_results [$];
   queue_result_type want_rsp;
   int unsigned      mismatch_count = 0;
   bit               gaps_on = 1'b1;

   function automatic void log_push(input fqu_pkg::kind_type kind,
                                    input logic [RBITS-1:0] h);
      log_kind[log_top] = kind;
      log_handle[log_top] = h;
      log_top = (log_top + 1) % HDEPTH;
      if (log_fill < HDEPTH)
         log_fill++;
   endfunction

   function automatic queue_result_type predict_queue_op(
      input logic [fqu_pkg::MODE_BITS-1:0] op,
      input logic [RBITS-1:0]              rec);
      queue_result_type res;
      logic [RBITS-1:0] h;
      res.status = fqu_pkg::STATUS_OK;
      res.record_out = '0;
      res.undone_kind = fqu_pkg::KIND_ENQ;
      h = rec & HANDLE_MASK;
      case (op)
         fqu_pkg::MODE_ENQ: begin
            if (fill >= QDEPTH) begin
               res.status = fqu_pkg::STATUS_FULL;
            end else begin
               slot_mem[(head_pos + fill) % QDEPTH] = h;
               fill++;
               log_push(fqu_pkg::KIND_ENQ, h);
            end
         end
         fqu_pkg::MODE_DEQ: begin
            if (fill == 0) begin
               res.status = fqu_pkg::STATUS_EMPTY;
            end else begin
               res.record_out = slot_mem[head_pos];
               head_pos = (head_pos + 1) % QDEPTH;
               fill--;
               log_push(fqu_pkg::KIND_DEQ, res.record_out);
            end
         end
         fqu_pkg::MODE_UNDO: begin
            if (log_fill == 0) begin
               res.status = fqu_pkg::STATUS_NONE;
            end else begin
               log_top = (log_top + HDEPTH - 1) % HDEPTH;
               log_fill--;
               h = log_handle[log_top] & HANDLE_MASK;
               if (log_kind[log_top] == fqu_pkg::KIND_ENQ) begin
                  if (fill == 0) begin
                     res.status = fqu_pkg::STATUS_EMPTY;
                  end else begin
                     fill--;
                     res.record_out = h;
                  end
               end else if (fill >= QDEPTH) begin
                  res.status = fqu_pkg::STATUS_FULL;
               end else begin
                  head_pos = (head_pos + QDEPTH - 1) % QDEPTH;
                  slot_mem[head_pos] = h;
                  fill++;
                  res.record_out = h;
                  res.undone_kind = fqu_pkg::KIND_DEQ;
               end
            end
         end
         default: ;
      endcase
      res.occupancy = OBITS'(fill);
      return res;
   endfunction

   function automatic logic [RBITS-1:0] random_handle();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return RBITS'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] mismatch %s: got %0h, want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Drive one operation and hold it until the transaction completes.
   task automatic send_op(input logic [fqu_pkg::MODE_BITS-1:0] op,
                          input logic [RBITS-1:0] rec);
      while (gaps_on && $urandom_range(99) < 14) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.mode <= op;
      req_if.record_id <= rec;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      pending_results.push_back(predict_queue_op(op, rec));
   endtask

   task automatic wait_for_drain();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      @(posedge clock);
   endtask

   task automatic test_empty_and_ignored();
      send_op(fqu_pkg::MODE_DEQ, '1);
      send_op(fqu_pkg::MODE_UNDO, '1);
      send_op(MODE_IGNORED, '1);
      send_op(MODE_IGNORED, '0);
   endtask

   task automatic test_enqueue_undo_pairs();
      send_op(fqu_pkg::MODE_ENQ, '0);
      send_op(fqu_pkg::MODE_ENQ, '1);
      send_op(fqu_pkg::MODE_DEQ, 16'h5A5A);
      send_op(fqu_pkg::MODE_UNDO, 16'hA5A5);
      send_op(fqu_pkg::MODE_UNDO, '0);
      send_op(fqu_pkg::MODE_UNDO, '1);
      send_op(fqu_pkg::MODE_UNDO, '0);
   endtask

   task automatic test_fill_to_capacity();
      for (int i = 0; i < QDEPTH; i++)
         send_op(fqu_pkg::MODE_ENQ,
                 (i % 2 == 0) ? 16'hAAAA ^ RBITS'(i) : 16'h5555 ^ RBITS'(i));
      send_op(fqu_pkg::MODE_ENQ, '1);
      send_op(MODE_IGNORED, 16'h1234);
   endtask

   task automatic test_undo_log_overflow();
      for (int i = 0; i < QDEPTH; i++)
         send_op(fqu_pkg::MODE_DEQ, RBITS'($urandom));
      for (int i = 0; i < 20; i++)
         send_op(fqu_pkg::MODE_ENQ, random_handle());
      for (int i = 0; i < HDEPTH + 2; i++)
         send_op(fqu_pkg::MODE_UNDO, RBITS'($urandom));
   endtask

   task automatic test_random_traffic(input int unsigned item_total);
      int unsigned issued;
      int unsigned enq_share;
      int unsigned deq_share;
      int unsigned pick;
      int unsigned burst;
      issued = 0;
      enq_share = 45;
      deq_share = 35;
      while (issued < item_total) begin
         // drift between filling, draining and balanced traffic
         if ($urandom_range(63) == 0) begin
            case ($urandom_range(2))
               0: begin
                  enq_share = 65;
                  deq_share = 15;
               end
               1: begin
                  enq_share = 15;
                  deq_share = 65;
               end
               default: begin
                  enq_share = 42;
                  deq_share = 38;
               end
            endcase
         end
         if ($urandom_range(39) == 0) begin
            burst = $urandom_range(HDEPTH + 4, 1);
            repeat (burst)
               send_op(fqu_pkg::MODE_UNDO, RBITS'($urandom));
            issued += burst;
         end else begin
            pick = $urandom_range(99);
            if (pick < enq_share) begin
               send_op(fqu_pkg::MODE_ENQ, random_handle());
               issued++;
            end else if (pick < enq_share + deq_share) begin
               send_op(fqu_pkg::MODE_DEQ, RBITS'($urandom));
               issued++;
            end else if (pick < 96) begin
               send_op(fqu_pkg::MODE_UNDO, RBITS'($urandom));
               issued++;
            end else begin
               send_op(MODE_IGNORED, RBITS'($urandom));
            end
         end
      end
   endtask

   task automatic test_back_to_back(input int unsigned item_total);
      gaps_on = 1'b0;
      test_random_traffic(item_total);
      gaps_on = 1'b1;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with no operation pending", rsp_if.status, 0);
         end else begin
            want_rsp = pending_results.pop_front();
            if (rsp_if.status !== want_rsp.status)
               report_mismatch("status", rsp_if.status, want_rsp.status);
            if (rsp_if.record_out !== want_rsp.record_out)
               report_mismatch("record_out", rsp_if.record_out, want_rsp.record_out);
            if (rsp_if.undone_kind !== want_rsp.undone_kind)
               report_mismatch("undone_kind", rsp_if.undone_kind, want_rsp.undone_kind);
            if (rsp_if.occupancy !== want_rsp.occupancy)
               report_mismatch("occupancy", rsp_if.occupancy, want_rsp.occupancy);
         end
      end
      rsp_if.ready <= !(gaps_on && $urandom_range(99) < 14);
   end

   initial begin
      int unsigned settle;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.mode <= fqu_pkg::MODE_ENQ;
      req_if.record_id <= '0;
      repeat (10)
         @(posedge clock);
      reset <= 1'b0;

      test_empty_and_ignored();
      test_enqueue_undo_pairs();
      test_fill_to_capacity();
      wait_for_drain();
      test_undo_log_overflow();
      test_random_traffic(450);
      wait_for_drain();
      test_random_traffic(450);
      test_back_to_back(150);

      req_if.valid <= 1'b0;
      settle = 0;
      while (pending_results.size() != 0 && settle < 1000) begin
         @(posedge clock);
         settle++;
      end
      repeat (4)
         @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never returned", pending_results.size(), 0);
      if (mismatch_count == 0) begin
         $display("** fifo_queue_with_undo_log: PASSED **");
      end else begin
         $display("** fifo_queue_with_undo_log: FAILED **");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("** fifo_queue_with_undo_log: FAILED **");
      $finish;
   end

endmodule
